// ----- sv/tarcc_pkg.sv -----
// Types and constants shared by the touch auto-repeat clock control block.
package tarcc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int REG_W      = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETTLE_TICKS = 2'd0,
    REG_REPEAT_DELAY = 2'd1,
    REG_REPEAT_RATE  = 2'd2,
    REG_TICKS_PER_S  = 2'd3
  } tarcc_reg_t;

  localparam logic [REG_W-1:0] SETTLE_RST = 8'd1;
  localparam logic [REG_W-1:0] DELAY_RST  = 8'd10;
  localparam logic [REG_W-1:0] RATE_RST   = 8'd1;
  localparam logic [REG_W-1:0] TPS_RST    = 8'd20;

  typedef enum logic [2:0] {
    ST_INIT    = 3'd0,
    ST_NEVER   = 3'd1,
    ST_WAIT    = 3'd2,
    ST_SETTLE  = 3'd3,
    ST_DELAY   = 3'd4,
    ST_RATE    = 3'd5,
    ST_EXPIRED = 3'd6,
    ST_ADDSEC  = 3'd7
  } tarcc_state_t;

  typedef struct packed {
    logic         inc_dec;
    logic         adv_sec;
    logic         clr;
    tarcc_state_t state;
  } tarcc_result_t;

endpackage

// ----- sv/touch_auto_repeat_clock_control_core.sv -----
// Top level of the touch auto-repeat clock control block.
// Each accepted request is one tick carrying the touch level; the controller
// takes its transition and counter update in the cycle the tick is accepted
// and the result (pulses and new state code) is registered, so one tick per
// cycle is sustained while the output does not stall. A skid stage behind the
// result register takes one further tick after the output stalls; in_stall
// rises only once that skid stage is full. Configuration writes take effect
// on the next tick and should be made while no tick is pending.
module touch_auto_repeat_clock_control_core #(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_touched,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_inc_dec_pulse,
  output logic                                out_advance_second_pulse,
  output logic                                out_touch_clear_pulse,
  output logic [2:0]                          out_state_code,
  input  logic                                cfg_we,
  input  logic [tarcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tarcc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tarcc_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;

  logic [REG_W-1:0] settle_ticks_r, delay_ticks_r, rate_ticks_r, tps_r;

  tarcc_state_t state_r, state_nxt;
  logic [COUNT_WIDTH-1:0] settle_cnt_r, settle_cnt_nxt;
  logic [COUNT_WIDTH-1:0] delay_cnt_r, delay_cnt_nxt;
  logic [COUNT_WIDTH-1:0] rate_cnt_r, rate_cnt_nxt;
  logic [COUNT_WIDTH-1:0] sec_cnt_r, sec_cnt_nxt;

  tarcc_result_t res_nxt, out_res_r, skid_res_r;
  logic          out_valid_r, skid_valid_r;

  logic accept, taken;
  logic settle_hit, delay_hit, rate_hit, sec_due;
  logic [COUNT_WIDTH-1:0] sec_base;

  assign accept   = in_valid && !in_stall;
  assign taken    = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  assign settle_hit = CMP_W'(settle_cnt_r) == CMP_W'(settle_ticks_r);
  assign delay_hit  = CMP_W'(delay_cnt_r) == CMP_W'(delay_ticks_r);
  assign rate_hit   = CMP_W'(rate_cnt_r) == CMP_W'(rate_ticks_r);
  assign sec_due    = CMP_W'(sec_cnt_r) >= CMP_W'(tps_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ticks_r <= SETTLE_RST;
      delay_ticks_r  <= DELAY_RST;
      rate_ticks_r   <= RATE_RST;
      tps_r          <= TPS_RST;
    end else if (cfg_we) begin
      unique case (tarcc_reg_t'(cfg_index))
        REG_SETTLE_TICKS: settle_ticks_r <= cfg_wdata;
        REG_REPEAT_DELAY: delay_ticks_r  <= cfg_wdata;
        REG_REPEAT_RATE:  rate_ticks_r   <= cfg_wdata;
        REG_TICKS_PER_S:  tps_r          <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // transition first, then the counter action of the new state
  always_comb begin
    state_nxt       = state_r;
    res_nxt.inc_dec = 1'b0;
    res_nxt.adv_sec = 1'b0;
    res_nxt.clr     = 1'b0;
    sec_base        = sec_cnt_r;

    unique case (state_r)
      ST_INIT: state_nxt = ST_NEVER;
      ST_NEVER: begin
        if (in_touched) begin
          res_nxt.clr = 1'b1;
          state_nxt   = ST_SETTLE;
        end
      end
      ST_WAIT: begin
        if (in_touched) begin
          res_nxt.clr = 1'b1;
          state_nxt   = ST_SETTLE;
        end
        if (sec_due) state_nxt = ST_ADDSEC;
      end
      ST_SETTLE: begin
        if (settle_hit) begin
          if (in_touched) begin
            state_nxt = ST_DELAY;
          end else begin
            res_nxt.inc_dec = 1'b1;
            state_nxt       = ST_WAIT;
          end
        end
      end
      ST_DELAY: begin
        if (!in_touched) begin
          res_nxt.inc_dec = 1'b1;
          state_nxt       = ST_WAIT;
        end else if (delay_hit) begin
          res_nxt.inc_dec = 1'b1;
          state_nxt       = ST_RATE;
        end
      end
      ST_RATE: begin
        if (!in_touched) state_nxt = ST_WAIT;
        else if (rate_hit) state_nxt = ST_EXPIRED;
      end
      ST_EXPIRED: begin
        if (!in_touched) begin
          state_nxt = ST_WAIT;
        end else begin
          res_nxt.inc_dec = 1'b1;
          state_nxt       = ST_RATE;
        end
      end
      ST_ADDSEC: begin
        res_nxt.adv_sec = 1'b1;
        sec_base        = '0;
        state_nxt       = ST_WAIT;
      end
      default: state_nxt = ST_INIT;
    endcase

    settle_cnt_nxt = settle_cnt_r;
    delay_cnt_nxt  = delay_cnt_r;
    rate_cnt_nxt   = rate_cnt_r;
    sec_cnt_nxt    = sec_base;

    unique case (state_nxt)
      ST_NEVER: begin
        settle_cnt_nxt = '0;
        delay_cnt_nxt  = '0;
        rate_cnt_nxt   = '0;
      end
      ST_WAIT: begin
        settle_cnt_nxt = '0;
        delay_cnt_nxt  = '0;
        rate_cnt_nxt   = '0;
        sec_cnt_nxt    = sec_base + 1'b1;
      end
      ST_SETTLE:  settle_cnt_nxt = settle_cnt_r + 1'b1;
      ST_DELAY:   delay_cnt_nxt  = delay_cnt_r + 1'b1;
      ST_RATE:    rate_cnt_nxt   = rate_cnt_r + 1'b1;
      ST_EXPIRED: rate_cnt_nxt   = '0;
      default: ;
    endcase

    res_nxt.state = state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      settle_cnt_r <= '0;
      delay_cnt_r  <= '0;
      rate_cnt_r   <= '0;
      sec_cnt_r    <= '0;
    end else if (accept) begin
      state_r      <= state_nxt;
      settle_cnt_r <= settle_cnt_nxt;
      delay_cnt_r  <= delay_cnt_nxt;
      rate_cnt_r   <= rate_cnt_nxt;
      sec_cnt_r    <= sec_cnt_nxt;
    end
  end

  // result register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        if (!out_valid_r || taken) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (taken) begin
        out_valid_r  <= skid_valid_r;
        skid_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_valid_r || taken) out_res_r <= res_nxt;
      else skid_res_r <= res_nxt;
    end else if (taken && skid_valid_r) begin
      out_res_r <= skid_res_r;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_inc_dec_pulse        = out_res_r.inc_dec;
  assign out_advance_second_pulse = out_res_r.adv_sec;
  assign out_touch_clear_pulse    = out_res_r.clr;
  assign out_state_code           = out_res_r.state;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full while result register empty");

  a_drop_only_when_taken: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(!out_stall))
    else $error("result dropped without being taken");

  a_adv_goes_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.adv_sec) |-> (out_res_r.state == ST_WAIT))
    else $error("advance pulse without return to waiting");

  a_clr_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.clr) |->
      (out_res_r.state == ST_SETTLE || out_res_r.state == ST_ADDSEC))
    else $error("touch clear pulse with unexpected state");

  a_state_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(state_r))
    else $error("controller state moved without a request");
`endif

endmodule
